>>> hw/rtl/dsrl_pkg.sv
package dsrl_pkg;

	localparam int CNT_W  = 48;
	localparam int TID_W  = 22;
	localparam int ADDR_W = 64;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TID_W-1:0]  tid_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [1:0] VERDICT_NONE      = 2'd0;
	localparam logic [1:0] VERDICT_REDUNDANT = 2'd1;
	localparam logic [1:0] VERDICT_DEAD      = 2'd2;
	localparam logic [1:0] VERDICT_FULL      = 2'd3;

	typedef enum logic [1:0] {
		OP_OTHER = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef struct packed {
		op_t   op;
		tid_t  tid;
		addr_t addr;
	} item_t;

	typedef struct packed {
		logic  last_was_write;
		cnt_t  write_index;
	} slot_data_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

endpackage

>>> hw/rtl/dsrl_front.sv
module dsrl_front import dsrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  tid_t        thread_id,
	input  addr_t       address,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      item_in;

	always_comb begin
		item_in.tid  = thread_id;
		item_in.addr = address;
		case (kind)
			KIND_READ:  item_in.op = OP_READ;
			KIND_WRITE: item_in.op = OP_WRITE;
			default:    item_in.op = OP_OTHER;
		endcase
	end

	assign busy    = (count_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/dsrl_back.sv
module dsrl_back import dsrl_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        done,
	output logic [1:0]  verdict,
	output cnt_t        report_index,
	output cnt_t        event_index,
	output cnt_t        reads_seen,
	output cnt_t        writes_seen,
	output cnt_t        dead_reads,
	output cnt_t        dead_writes
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_MATCH   = 4'b0010,
		S_ENCODE  = 4'b0100,
		S_RESOLVE = 4'b1000
	} state_t;

	state_t                   state_q;
	item_t                    item_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	tid_t                     tag_tid_q  [TABLE_ENTRIES];
	addr_t                    tag_addr_q [TABLE_ENTRIES];
	slot_data_t               slot_mem   [TABLE_ENTRIES];
	slot_data_t               rdata_q;
	logic [TABLE_ENTRIES-1:0] match_q;
	logic [TABLE_ENTRIES-1:0] free_q;
	logic [IDX_W-1:0]         slot_q;
	logic                     hit_q;
	logic                     room_q;
	logic [IDX_W-1:0]         enc_idx;
	logic                     enc_hit;
	logic                     enc_room;
	logic [IDX_W-1:0]         hit_idx;
	logic [IDX_W-1:0]         free_idx;
	cnt_t                     index_q;
	cnt_t                     reads_q;
	cnt_t                     writes_q;
	cnt_t                     dead_reads_q;
	cnt_t                     dead_writes_q;
	logic                     done_q;
	logic [1:0]               verdict_q;
	cnt_t                     report_q;
	logic                     mem_we;
	slot_data_t               mem_wdata;
	logic                     insert;
	logic [1:0]               verdict_n;
	cnt_t                     report_n;
	cnt_t                     index_n;
	logic                     is_acc;
	logic                     is_wr;

	assign q_pop = q_valid && ((state_q == S_IDLE) || (state_q == S_RESOLVE));

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (free_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		enc_hit  = |match_q;
		enc_room = |free_q;
		enc_idx  = enc_hit ? hit_idx : free_idx;
	end

	always_comb begin
		is_acc    = (item_q.op == OP_READ) || (item_q.op == OP_WRITE);
		is_wr     = (item_q.op == OP_WRITE);
		index_n   = sat_inc(index_q);
		verdict_n = VERDICT_NONE;
		report_n  = '0;
		mem_we    = 1'b0;
		mem_wdata = rdata_q;
		insert    = 1'b0;
		if (is_acc) begin
			if (hit_q) begin
				mem_we = 1'b1;
				if (!is_wr) begin
					if (!rdata_q.last_was_write) begin
						verdict_n = VERDICT_REDUNDANT;
						report_n  = index_n;
					end
					mem_wdata.last_was_write = 1'b0;
				end else begin
					if (rdata_q.last_was_write) begin
						verdict_n = VERDICT_DEAD;
						report_n  = rdata_q.write_index;
					end
					mem_wdata.last_was_write = 1'b1;
					mem_wdata.write_index    = index_n;
				end
			end else if (room_q) begin
				mem_we                   = 1'b1;
				insert                   = 1'b1;
				mem_wdata.last_was_write = is_wr;
				mem_wdata.write_index    = index_n;
			end else begin
				verdict_n = VERDICT_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == S_MATCH) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				match_q[i] <= valid_q[i] && (tag_tid_q[i] == item_q.tid)
					&& (tag_addr_q[i] == item_q.addr);
				free_q[i]  <= !valid_q[i];
			end
		end
		if (state_q == S_ENCODE) begin
			slot_q  <= enc_idx;
			hit_q   <= enc_hit;
			room_q  <= enc_room;
			rdata_q <= slot_mem[enc_idx];
		end
		if ((state_q == S_RESOLVE) && mem_we) begin
			slot_mem[slot_q] <= mem_wdata;
		end
		if ((state_q == S_RESOLVE) && insert) begin
			tag_tid_q[slot_q]  <= item_q.tid;
			tag_addr_q[slot_q] <= item_q.addr;
		end
		if (state_q == S_RESOLVE) begin
			verdict_q <= verdict_n;
			report_q  <= report_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			valid_q       <= '0;
			index_q       <= '0;
			reads_q       <= '0;
			writes_q      <= '0;
			dead_reads_q  <= '0;
			dead_writes_q <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= (state_q == S_RESOLVE);
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_ENCODE;
				end
				S_ENCODE: begin
					state_q <= S_RESOLVE;
				end
				S_RESOLVE: begin
					state_q <= q_pop ? S_MATCH : S_IDLE;
					index_q <= index_n;
					if (is_acc && is_wr) begin
						writes_q <= sat_inc(writes_q);
					end
					if (is_acc && !is_wr) begin
						reads_q <= sat_inc(reads_q);
					end
					if (verdict_n == VERDICT_REDUNDANT) begin
						dead_reads_q <= sat_inc(dead_reads_q);
					end
					if (verdict_n == VERDICT_DEAD) begin
						dead_writes_q <= sat_inc(dead_writes_q);
					end
					if (insert) begin
						valid_q[slot_q] <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign verdict      = verdict_q;
	assign report_index = report_q;
	assign event_index  = index_q;
	assign reads_seen   = reads_q;
	assign writes_seen  = writes_q;
	assign dead_reads   = dead_reads_q;
	assign dead_writes  = dead_writes_q;

endmodule

>>> hw/rtl/dead_store_redundant_load_monitor.sv
// Dead-store and redundant-load monitor.
// Input: drive kind, thread_id and address with start high; the record is
// taken at a rising edge where start is high and busy is low. busy rises
// only when the two-entry record queue between the front and back is full.
// Output: one result per record, valid when done, a one-cycle strobe, is
// high: verdict, report_index, event_index and the running counters
// reads_seen, writes_seen, dead_reads and dead_writes (all saturating).
// Path: when the back end is idle, a record goes through the queue, tag
// match, slot encode with slot memory read, resolve and the output
// register. The back end pops the next record only from idle or in the
// resolve step of the last one, so the match/encode/resolve sequence around
// the tag table and its single-port slot memory never overlaps.
// The receiver cannot stall; done is a strobe and results stay only until the next record resolves.
// Reset (arst_n low) empties the queue, clears all table valid bits and
// zeroes the event index and counters; no clearing pass is needed.
// The table holds TABLE_ENTRIES keys; new keys fill the lowest free slot
// and records for new keys beyond that are flagged as untracked.
module dead_store_redundant_load_monitor import dsrl_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  tid_t        thread_id,
	input  addr_t       address,
	output logic        done,
	output logic [1:0]  verdict,
	output cnt_t        report_index,
	output cnt_t        event_index,
	output cnt_t        reads_seen,
	output cnt_t        writes_seen,
	output cnt_t        dead_reads,
	output cnt_t        dead_writes
);

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	dsrl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.thread_id (thread_id),
		.address   (address),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	dsrl_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.done         (done),
		.verdict      (verdict),
		.report_index (report_index),
		.event_index  (event_index),
		.reads_seen   (reads_seen),
		.writes_seen  (writes_seen),
		.dead_reads   (dead_reads),
		.dead_writes  (dead_writes)
	);

endmodule

>>> verif/testbench.sv
module testbench;
	import dsrl_pkg::*;

	localparam int SLOTS = 64;
	localparam int WATCH_LIMIT = 1000;
	localparam int ECHO_LIMIT = 40;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0] verdict;
		cnt_t       report_index;
		cnt_t       event_index;
		cnt_t       reads_seen;
		cnt_t       writes_seen;
		cnt_t       dead_reads;
		cnt_t       dead_writes;
	} verdict_rec_t;

	class verdict_board;
		bit           used [SLOTS];
		tid_t         key_tid [SLOTS];
		addr_t        key_addr [SLOTS];
		bit           last_wr [SLOTS];
		cnt_t         wr_index [SLOTS];
		cnt_t         index_now;
		cnt_t         read_total;
		cnt_t         write_total;
		cnt_t         redundant_total;
		cnt_t         dead_total;
		verdict_rec_t awaited [$];
		int           mismatches;

		function new();
			foreach (used[i]) begin
				used[i] = 1'b0;
			end
			index_now = '0;
			read_total = '0;
			write_total = '0;
			redundant_total = '0;
			dead_total = '0;
			mismatches = 0;
		endfunction

		function cnt_t bump(cnt_t v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function void note_record(logic [1:0] k, tid_t t, addr_t a);
			verdict_rec_t rec;
			int hit;
			int free_slot;
			bit wr;
			rec = '0;
			hit = -1;
			free_slot = -1;
			index_now = bump(index_now);
			if (k == KIND_READ || k == KIND_WRITE) begin
				wr = (k == KIND_WRITE);
				if (wr) begin
					write_total = bump(write_total);
				end else begin
					read_total = bump(read_total);
				end
				for (int i = 0; i < SLOTS; i++) begin
					if (used[i]) begin
						if (hit < 0 && key_tid[i] == t && key_addr[i] == a) begin
							hit = i;
						end
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (hit >= 0) begin
					if (!wr) begin
						if (!last_wr[hit]) begin
							rec.verdict = VERDICT_REDUNDANT;
							rec.report_index = index_now;
							redundant_total = bump(redundant_total);
						end
						last_wr[hit] = 1'b0;
					end else begin
						if (last_wr[hit]) begin
							rec.verdict = VERDICT_DEAD;
							rec.report_index = wr_index[hit];
							dead_total = bump(dead_total);
						end
						last_wr[hit] = 1'b1;
						wr_index[hit] = index_now;
					end
				end else if (free_slot >= 0) begin
					used[free_slot] = 1'b1;
					key_tid[free_slot] = t;
					key_addr[free_slot] = a;
					last_wr[free_slot] = wr;
					if (wr) begin
						wr_index[free_slot] = index_now;
					end
				end else begin
					rec.verdict = VERDICT_FULL;
				end
			end
			rec.event_index = index_now;
			rec.reads_seen = read_total;
			rec.writes_seen = write_total;
			rec.dead_reads = redundant_total;
			rec.dead_writes = dead_total;
			awaited.insert(awaited.size(), rec);
		endfunction

		task flag(string msg);
			mismatches++;
			if (mismatches <= ECHO_LIMIT) begin
				$display("mismatch: %s", msg);
			end
		endtask

		task match_field(string name, cnt_t got, cnt_t want);
			if (got !== want) begin
				flag($sformatf("%s got %h want %h (event %0d)", name, got, want,
					index_now));
			end
		endtask

		task check_verdict(verdict_rec_t got);
			verdict_rec_t want;
			if (awaited.size() == 0) begin
				flag("result with no record in flight");
			end else begin
				want = awaited.pop_front();
				match_field("verdict", cnt_t'(got.verdict), cnt_t'(want.verdict));
				match_field("report_index", got.report_index, want.report_index);
				match_field("event_index", got.event_index, want.event_index);
				match_field("reads_seen", got.reads_seen, want.reads_seen);
				match_field("writes_seen", got.writes_seen, want.writes_seen);
				match_field("dead_reads", got.dead_reads, want.dead_reads);
				match_field("dead_writes", got.dead_writes, want.dead_writes);
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] kind = '0;
	tid_t       thread_id = '0;
	addr_t      address = '0;
	logic       busy;
	logic       done;
	logic [1:0] verdict;
	cnt_t       report_index;
	cnt_t       event_index;
	cnt_t       reads_seen;
	cnt_t       writes_seen;
	cnt_t       dead_reads;
	cnt_t       dead_writes;

	verdict_board board;
	tid_t         pool_tid [$];
	addr_t        pool_addr [$];
	bit           calm = 1'b0;
	int           quiet = 0;

	dead_store_redundant_load_monitor #(
		.TABLE_ENTRIES(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.thread_id(thread_id),
		.address(address),
		.done(done),
		.verdict(verdict),
		.report_index(report_index),
		.event_index(event_index),
		.reads_seen(reads_seen),
		.writes_seen(writes_seen),
		.dead_reads(dead_reads),
		.dead_writes(dead_writes)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note_record(kind, thread_id, address);
			end
			if (done) begin
				board.check_verdict('{verdict, report_index, event_index, reads_seen,
					writes_seen, dead_reads, dead_writes});
			end
			if ((start && !busy) || done) begin
				quiet = 0;
			end else begin
				quiet = quiet + 1;
			end
			if (quiet >= WATCH_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic transfer_record(logic [1:0] k, tid_t t, addr_t a);
		int n;
		start <= 1'b1;
		kind <= k;
		thread_id <= t;
		address <= a;
		do @(posedge clk); while (busy);
		if (!calm && $urandom_range(0, 99) < 29) begin
			n = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (board.awaited.size() != 0);
	endtask

	task automatic random_record(int fresh_pct);
		int    pick;
		int    roll;
		int    b;
		tid_t  t;
		addr_t a;
		logic [1:0] k;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			k = OP_OTHER;
		end else if (roll < 11) begin
			k = KIND_SPARE;
		end else if (roll < 55) begin
			k = KIND_READ;
		end else begin
			k = KIND_WRITE;
		end
		pick = $urandom_range(0, pool_tid.size() - 1);
		t = pool_tid[pick];
		a = pool_addr[pick];
		roll = $urandom_range(0, 99);
		if (roll < fresh_pct) begin
			t = tid_t'($urandom);
			a = {$urandom, $urandom};
		end else if (roll < fresh_pct + 4) begin
			// near miss: one key bit off
			if ($urandom_range(0, 1)) begin
				b = $urandom_range(0, TID_W - 1);
				t[b] = ~t[b];
			end else begin
				b = $urandom_range(0, ADDR_W - 1);
				a[b] = ~a[b];
			end
		end
		if (roll < fresh_pct + 4 && $urandom_range(0, 1)) begin
			pool_tid.insert(pool_tid.size(), t);
			pool_addr.insert(pool_addr.size(), a);
		end
		transfer_record(k, t, a);
	endtask

	initial begin
		tid_t  t;
		addr_t a;
		board = new();
		pool_tid.insert(pool_tid.size(), '0);
		pool_addr.insert(pool_addr.size(), '1);
		pool_tid.insert(pool_tid.size(), '1);
		pool_addr.insert(pool_addr.size(), '0);
		for (int i = 2; i < 40; i++) begin
			t = tid_t'($urandom);
			a = {$urandom, $urandom};
			if (i % 5 == 1) begin
				t = pool_tid[i - 1];
			end
			if (i % 5 == 2) begin
				a = pool_addr[i - 1];
			end
			pool_tid.insert(pool_tid.size(), t);
			pool_addr.insert(pool_addr.size(), a);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		transfer_record(OP_OTHER, '1, '1);
		transfer_record(KIND_SPARE, '0, '0);
		transfer_record(KIND_READ, '0, '0);
		transfer_record(KIND_READ, '0, '0);
		transfer_record(KIND_WRITE, '0, '0);
		transfer_record(KIND_WRITE, '0, '0);
		transfer_record(KIND_READ, '0, '0);
		transfer_record(KIND_WRITE, '1, '1);
		transfer_record(KIND_WRITE, '1, '1);
		transfer_record(OP_OTHER, '1, '1);
		transfer_record(KIND_WRITE, '1, '1);
		transfer_record(KIND_READ, '1, '1);
		transfer_record(KIND_READ, '1, '1);
		transfer_record(KIND_READ, '1, '0);
		transfer_record(KIND_WRITE, '0, '1);
		transfer_record(KIND_WRITE, '1, '0);
		transfer_record(KIND_SPARE, '1, '1);
		transfer_record(KIND_READ, '0, '1);
		drain_results();

		for (int i = 0; i < 500; i++) begin
			calm = (i >= 250);
			if (i == 100) begin
				drain_results();
			end
			random_record(1);
		end
		calm = 1'b0;
		for (int i = 0; i < 700; i++) begin
			random_record(15);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.awaited.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/dsrl_pkg.sv
hw/rtl/dsrl_front.sv
hw/rtl/dsrl_back.sv
hw/rtl/dead_store_redundant_load_monitor.sv
verif/testbench.sv
